/* src/scet_pkg.sv */
// Shared types and constants for the scope capture edge-trigger core.
// No dependencies; every other file in src imports this package.
package scet_pkg;

  localparam int IndexBits    = 11;
  localparam int SampleInBits = 12;
  localparam int LevelBits    = 12;
  localparam int CountBits    = 32;

  localparam logic [LevelBits-1:0] LevelReset = 12'd2048;

  // Transaction kinds on the input channel.
  localparam logic KindStore  = 1'b0;
  localparam logic KindSearch = 1'b1;

  typedef enum logic [1:0] {
    SRCH_IDLE,
    SRCH_PRIME,
    SRCH_SCAN,
    SRCH_DONE
  } srch_state_t;

endpackage

/* src/scet_ring.sv */
// Sample ring memory: one write port, one registered read port.
// Depends on scet_pkg. A fill count makes never-written entries read as zero.
module scet_ring #(
  parameter int RING_DEPTH  = 2048,
  parameter int SAMPLE_BITS = 12,
  localparam int AW = $clog2(RING_DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [SAMPLE_BITS-1:0] wr_data,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output logic [SAMPLE_BITS-1:0] rd_data
);
  import scet_pkg::*;

  localparam logic [AW:0] DepthCount = (AW+1)'(RING_DEPTH);

  logic [SAMPLE_BITS-1:0] mem [RING_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_q;
  logic                   rd_live;
  logic [AW:0]            fill;

  // Writes land in ring order starting at entry zero, so an entry holds
  // real data exactly when its address is below the number of writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (wr_en && (fill != DepthCount)) begin
      fill <= fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q    <= mem[rd_addr];
      rd_live <= ({1'b0, rd_addr} < fill);
    end
  end

  assign rd_data = rd_live ? rd_q : '0;

endmodule

/* src/scet_search.sv */
// Edge search sequencer: walks the ring backward one read per cycle.
// Depends on scet_pkg; drives the read port of scet_ring.
module scet_search #(
  parameter int RING_DEPTH   = 2048,
  parameter int SCREEN_WIDTH = 128,
  parameter int SAMPLE_BITS  = 12,
  localparam int AW = $clog2(RING_DEPTH)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           falling,
  input  logic [scet_pkg::LevelBits-1:0] level,
  input  logic [AW-1:0]                  newest,
  output logic                           rd_en,
  output logic [AW-1:0]                  rd_addr,
  input  logic [SAMPLE_BITS-1:0]         rd_data,
  output logic                           idle,
  output logic                           res_valid,
  output logic [AW-1:0]                  res_pos,
  output logic                           res_not_found,
  input  logic                           res_take
);
  import scet_pkg::*;

  localparam int HALF   = RING_DEPTH / 2;
  localparam int CNTW   = $clog2(HALF);
  localparam int OFFSET = (SCREEN_WIDTH / 2) % RING_DEPTH;
  localparam int CW     = (SAMPLE_BITS > LevelBits) ? SAMPLE_BITS : LevelBits;
  localparam logic [AW-1:0]   LastPos  = AW'(RING_DEPTH - 1);
  localparam logic [CNTW-1:0] LastStep = CNTW'(HALF - 1);

  srch_state_t            state, state_next;
  logic [AW-1:0]          start_pos, cur_pos, nxt_addr, start_calc;
  logic [SAMPLE_BITS-1:0] cur_val;
  logic [CNTW-1:0]        cnt;
  logic                   fall;
  logic                   cur_ge, old_ge, hit, last;

  function automatic logic [AW-1:0] pos_dec(input logic [AW-1:0] p);
    return (p == '0) ? LastPos : p - 1'b1;
  endfunction

  always_comb begin
    if (newest >= AW'(OFFSET)) begin
      start_calc = newest - AW'(OFFSET);
    end else begin
      start_calc = newest + AW'(RING_DEPTH - OFFSET);
    end
  end

  // cur_val is the sample at cur_pos; rd_data is its older neighbor.
  assign cur_ge = CW'(cur_val) >= CW'(level);
  assign old_ge = CW'(rd_data) >= CW'(level);
  assign hit    = fall ? (!cur_ge && old_ge) : (cur_ge && !old_ge);
  assign last   = (cnt == LastStep);

  always_comb begin
    state_next = state;
    unique case (state)
      SRCH_IDLE:  if (start) state_next = SRCH_PRIME;
      SRCH_PRIME: state_next = SRCH_SCAN;
      SRCH_SCAN:  if (hit || last) state_next = SRCH_DONE;
      SRCH_DONE:  if (res_take) state_next = SRCH_IDLE;
      default:    state_next = SRCH_IDLE;
    endcase
  end

  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = nxt_addr;
    idle      = 1'b0;
    res_valid = 1'b0;
    unique case (state)
      SRCH_IDLE: begin
        idle    = 1'b1;
        rd_en   = start;
        rd_addr = start_calc;
      end
      SRCH_PRIME: rd_en = 1'b1;
      SRCH_SCAN:  rd_en = !(hit || last);
      SRCH_DONE:  res_valid = 1'b1;
      default:    rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SRCH_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      SRCH_IDLE: begin
        if (start) begin
          start_pos <= start_calc;
          cur_pos   <= start_calc;
          nxt_addr  <= pos_dec(start_calc);
          cnt       <= '0;
          fall      <= falling;
        end
      end
      SRCH_PRIME: begin
        cur_val  <= rd_data;
        nxt_addr <= pos_dec(nxt_addr);
      end
      SRCH_SCAN: begin
        if (hit) begin
          res_pos       <= cur_pos;
          res_not_found <= 1'b0;
        end else if (last) begin
          res_pos       <= start_pos;
          res_not_found <= 1'b1;
        end else begin
          cur_val  <= rd_data;
          cur_pos  <= pos_dec(cur_pos);
          nxt_addr <= pos_dec(nxt_addr);
          cnt      <= cnt + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/scope_capture_edge_trigger_core.sv */
// Scope capture ring with edge-trigger search.
// A store transaction leaves the port ready, so stores can follow back to back.
// A search holds the input port until its result is taken from the engine: one ring read
// per compared position, set by the single read port of the sample memory.
// Reset is synchronous; the ring reads as zero until written, with no clearing
// pass, and the trigger level returns to mid scale.
module scope_capture_edge_trigger_core #(
  parameter int RING_DEPTH   = 2048,
  parameter int SCREEN_WIDTH = 128,
  parameter int SAMPLE_BITS  = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [scet_pkg::LevelBits-1:0]    cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              kind,
  input  logic [scet_pkg::SampleInBits-1:0] sample,
  input  logic                              overflow,
  input  logic                              falling_edge,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [scet_pkg::IndexBits-1:0]    trigger_index,
  output logic                              not_found,
  output logic [scet_pkg::CountBits-1:0]    error_count
);
  import scet_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam logic [AW-1:0] LastPos = AW'(RING_DEPTH - 1);

  logic [LevelBits-1:0] trigger_level;
  logic [AW-1:0]        newest, write_pos;
  logic [CountBits-1:0] overflow_count;

  logic                   in_fire, store_fire, search_fire;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic                   srch_idle, res_valid, res_not_found, res_take;
  logic [AW-1:0]          res_pos;

  // The search engine owns the input port: stores are taken only while it is
  // idle, so a write never races a search read and no forwarding is needed.
  // A finished result moves to the output register once that is free, so new
  // transactions flow while the consumer stalls; a second result waits in the engine.
  assign in_ready    = srch_idle;
  assign in_fire     = in_valid && in_ready;
  assign store_fire  = in_fire && (kind == KindStore);
  assign search_fire = in_fire && (kind == KindSearch);

  assign write_pos = (newest == LastPos) ? '0 : newest + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_level <= LevelReset;
    end else if (cfg_wr_en) begin
      trigger_level <= cfg_wr_data;
    end
  end

  // Ring pointer and converter overflow count advance only on stores.
  always_ff @(posedge clk) begin
    if (rst) begin
      newest         <= LastPos;
      overflow_count <= '0;
    end else if (store_fire) begin
      newest <= write_pos;
      if (overflow) begin
        overflow_count <= overflow_count + 1'b1;
      end
    end
  end

  scet_ring #(
    .RING_DEPTH  (RING_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (store_fire),
    .wr_addr (write_pos),
    .wr_data (SAMPLE_BITS'(sample)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  scet_search #(
    .RING_DEPTH   (RING_DEPTH),
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_search (
    .clk           (clk),
    .rst           (rst),
    .start         (search_fire),
    .falling       (falling_edge),
    .level         (trigger_level),
    .newest        (newest),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .idle          (srch_idle),
    .res_valid     (res_valid),
    .res_pos       (res_pos),
    .res_not_found (res_not_found),
    .res_take      (res_take)
  );

  // No store can land between the search and the load of its result, so the
  // live overflow count is the count as of the search transaction.
  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      trigger_index <= IndexBits'(res_pos);
      not_found     <= res_not_found;
      error_count   <= overflow_count;
    end
  end

`ifndef SYNTHESIS
  a_store_only_when_idle: assert property (@(posedge clk) disable iff (rst)
    store_fire |-> (srch_idle && !rd_en))
    else $error("store accepted while a search reads the ring");

  a_overflow_counts: assert property (@(posedge clk) disable iff (rst)
    (store_fire && overflow) |=> (overflow_count == $past(overflow_count) + 32'd1))
    else $error("overflow count did not advance on a flagged store");

  a_search_blocks_input: assert property (@(posedge clk) disable iff (rst)
    search_fire |=> !in_ready)
    else $error("input port stayed ready after a search was accepted");
`endif

endmodule
